// ===== rtl/iibb_pkg.sv =====
// Shared types and constants for the integral image box blur.
package iibb_pkg;

    localparam int PIX_W = 8;
    localparam int SUM_W = 24;
    localparam int RSUM_W = 16;
    localparam int CNT_W = 9;
    localparam int RAD_W = 5;
    localparam int ADDR_W = 4;

    localparam logic [ADDR_W-1:0] REG_RADIUS = 4'h0;
    localparam logic [ADDR_W-1:0] REG_COLS = 4'h4;
    localparam logic [ADDR_W-1:0] REG_ROWS = 4'h8;

    localparam logic [RAD_W-1:0] RADIUS_RST = 5'd10;
    localparam logic [CNT_W-1:0] DIM_RST = 9'd256;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // One word passed from the front end to the back end.
    typedef struct packed {
        logic op;
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] row;
        logic [PIX_W-1:0] col;
    } cmd_t;

endpackage

// ===== rtl/integral_image_box_blur.sv =====
// Top level of the integral image box blur: config registers, front end, back end.
//
//  channel | handshake            | payload
//  command | start / busy         | op, pixel, row, col
//  result  | strobe (1 cycle)     | blurred
//  config  | APB psel/penable     | radius, image_cols, image_rows
//
// A load reads the integral memory and writes one sum; a fetch runs setup, four reads
// from the single-port integral memory and the sum, then the 24-step serial divider;
// the strobe comes with the divider's done, at the end of the fetch.
// A two-word queue sits between front and back; busy rises when it is full.
// Reset clears the load position and config; the memory is undefined until loaded.
// The receiver cannot stall: strobe marks each result for one cycle.
module integral_image_box_blur
#(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic op,
    input  logic [7:0] pixel,
    input  logic [7:0] row,
    input  logic [7:0] col,
    output logic strobe,
    output logic [7:0] blurred,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [3:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);

    logic [4:0] radius_reg;
    logic [8:0] cols_reg;
    logic [8:0] rows_reg;
    logic wr;
    iibb_pkg::cmd_t cmd;
    iibb_pkg::cmd_t q_cmd;
    logic q_valid;
    logic q_pop;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= iibb_pkg::RADIUS_RST;
            cols_reg <= iibb_pkg::DIM_RST;
            rows_reg <= iibb_pkg::DIM_RST;
        end
        else if (wr)
        begin
            case (paddr)
                iibb_pkg::REG_RADIUS: radius_reg <= pwdata[4:0];
                iibb_pkg::REG_COLS: cols_reg <= pwdata[8:0];
                iibb_pkg::REG_ROWS: rows_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            iibb_pkg::REG_RADIUS: prdata = {27'd0, radius_reg};
            iibb_pkg::REG_COLS: prdata = {23'd0, cols_reg};
            iibb_pkg::REG_ROWS: prdata = {23'd0, rows_reg};
            default: prdata = 32'd0;
        endcase
    end

    assign cmd = '{op: op, pixel: pixel, row: row, col: col};

    iibb_front u_front
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cmd_in(cmd),
        .busy(busy),
        .q_valid(q_valid),
        .q_cmd(q_cmd),
        .q_pop(q_pop)
    );

    iibb_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back
    (
        .clk(clk),
        .rst_n(rst_n),
        .q_valid(q_valid),
        .q_cmd(q_cmd),
        .q_pop(q_pop),
        .radius(radius_reg),
        .image_cols(cols_reg),
        .image_rows(rows_reg),
        .result_valid(strobe),
        .blurred(blurred)
    );

    a_pop_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe) else $error("result strobe held");
    a_no_pop_on_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !$past(q_pop)) else $error("pop during divide");

endmodule

// ===== rtl/iibb_front.sv =====
// Front end: accepts commands and holds them in a two-entry queue.
module iibb_front
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  iibb_pkg::cmd_t cmd_in,
    output logic busy,
    output logic q_valid,
    output iibb_pkg::cmd_t q_cmd,
    input  logic q_pop
);

    iibb_pkg::cmd_t buf_reg [2];
    logic [0:0] rd_ptr_reg;
    logic [0:0] wr_ptr_reg;
    logic [1:0] count_reg;
    logic push;

    assign busy = (count_reg == 2'd2);
    assign push = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd = buf_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

// ===== rtl/iibb_div.sv =====
// Restoring divider: 24-bit sum by 18-bit count, one quotient bit a cycle.
module iibb_div
(
    input  logic clk,
    input  logic rst_n,
    input  logic go,
    input  logic [23:0] dividend,
    input  logic [17:0] divisor,
    output logic done,
    output logic [7:0] quot_sat
);

    logic [23:0] q_reg;
    logic [18:0] rem_reg;
    logic [17:0] dvs_reg;
    logic [4:0] cnt_reg;
    logic run_reg;
    logic [18:0] shifted;
    logic [19:0] diff;

    assign shifted = {rem_reg[17:0], q_reg[23]};
    assign diff = {1'b0, shifted} - {2'b00, dvs_reg};
    assign quot_sat = (q_reg[23:8] != 16'd0) ? 8'hFF : q_reg[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= 5'd0;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 5'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd23)
                begin
                    run_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg <= dividend;
            rem_reg <= 19'd0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            if (!diff[19])
            begin
                rem_reg <= diff[18:0];
                q_reg <= {q_reg[22:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg <= {q_reg[22:0], 1'b0};
            end
        end
    end

endmodule

// ===== rtl/iibb_back.sv =====
// Back end: integral memory, load sequencing and fetch window evaluation.
module iibb_back
#(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  iibb_pkg::cmd_t q_cmd,
    output logic q_pop,
    input  logic [iibb_pkg::RAD_W-1:0] radius,
    input  logic [iibb_pkg::CNT_W-1:0] image_cols,
    input  logic [iibb_pkg::CNT_W-1:0] image_rows,
    output logic result_valid,
    output logic [iibb_pkg::PIX_W-1:0] blurred
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int AW = CW + RW;
    localparam int DW = 13;
    localparam int RSUM_W = iibb_pkg::RSUM_W;

    typedef enum logic [3:0] {
        S_IDLE, S_LRD, S_LWR, S_FSET, S_FRD0, S_FRD1, S_FRD2, S_FRD3,
        S_FSUM, S_FDIV, S_FWAIT
    } state_t;

    state_t state_reg;
    logic [iibb_pkg::SUM_W-1:0] mem [MAX_ROWS*MAX_COLS];
    logic [iibb_pkg::SUM_W-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic rd_en;

    logic [iibb_pkg::RSUM_W-1:0] rsum_reg;
    logic [DW-1:0] lcol_reg;
    logic [DW-1:0] lrow_reg;
    logic [iibb_pkg::PIX_W-1:0] px_reg;
    logic [DW-1:0] y0_reg, y1_reg, x0_reg, x1_reg;
    logic [iibb_pkg::SUM_W-1:0] acc_reg;
    logic [17:0] area_reg;
    logic div_go_reg;
    logic div_done;
    logic [7:0] quot;

    logic [DW-1:0] cols_eff, rows_eff, yc, xc, ty, tx;
    logic [DW-1:0] rad_ext;
    logic [DW-1:0] col_nxt, row_nxt;
    logic [iibb_pkg::RSUM_W-1:0] rsum_new;
    logic [DW-1:0] ry, rx;
    logic rd_zero;

    assign rad_ext = DW'(radius);
    always_comb
    begin
        if (image_cols == '0)
            cols_eff = DW'(1);
        else if (DW'(image_cols) > DW'(MAX_COLS))
            cols_eff = DW'(MAX_COLS);
        else
            cols_eff = DW'(image_cols);
        if (image_rows == '0)
            rows_eff = DW'(1);
        else if (DW'(image_rows) > DW'(MAX_ROWS))
            rows_eff = DW'(MAX_ROWS);
        else
            rows_eff = DW'(image_rows);
        yc = (DW'(q_cmd.row) >= rows_eff) ? rows_eff - DW'(1) : DW'(q_cmd.row);
        xc = (DW'(q_cmd.col) >= cols_eff) ? cols_eff - DW'(1) : DW'(q_cmd.col);
        ty = yc + rad_ext;
        tx = xc + rad_ext;
        rsum_new = (lcol_reg == '0) ? RSUM_W'(px_reg)
                                    : rsum_reg + RSUM_W'(px_reg);
        col_nxt = lcol_reg + DW'(1);
        row_nxt = lrow_reg;
        if (col_nxt >= cols_eff)
        begin
            col_nxt = '0;
            row_nxt = lrow_reg + DW'(1);
            if (row_nxt >= rows_eff)
                row_nxt = '0;
        end
    end

    // Read address of the corner for each read state; a -1 index reads zero.
    always_comb
    begin
        ry = '0;
        rx = '0;
        rd_zero = 1'b0;
        rd_en = 1'b0;
        case (state_reg)
            S_LRD:
            begin
                rd_en = 1'b1;
                ry = lrow_reg - DW'(1);
                rx = lcol_reg;
                rd_zero = (lrow_reg == '0);
            end
            S_FRD0:
            begin
                rd_en = 1'b1;
                ry = y0_reg;
                rx = x0_reg;
            end
            S_FRD1:
            begin
                rd_en = 1'b1;
                ry = y1_reg - DW'(1);
                rx = x0_reg;
                rd_zero = (y1_reg == '0);
            end
            S_FRD2:
            begin
                rd_en = 1'b1;
                ry = y0_reg;
                rx = x1_reg - DW'(1);
                rd_zero = (x1_reg == '0);
            end
            S_FRD3:
            begin
                rd_en = 1'b1;
                ry = y1_reg - DW'(1);
                rx = x1_reg - DW'(1);
                rd_zero = (y1_reg == '0) || (x1_reg == '0);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
        rd_addr = {ry[RW-1:0], rx[CW-1:0]};
    end

    logic zero_reg;
    logic lwr_ok;
    assign lwr_ok = (lrow_reg < DW'(MAX_ROWS)) && (lcol_reg < DW'(MAX_COLS));

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (state_reg == S_LWR && lwr_ok)
        begin
            mem[{lrow_reg[RW-1:0], lcol_reg[CW-1:0]}] <=
                iibb_pkg::SUM_W'(rsum_new) + (zero_reg ? '0 : rd_data_reg);
        end
    end

    logic [iibb_pkg::SUM_W-1:0] rd_val;
    assign rd_val = zero_reg ? '0 : rd_data_reg;
    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign result_valid = div_done;
    assign blurred = quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rsum_reg <= '0;
            lcol_reg <= '0;
            lrow_reg <= '0;
            div_go_reg <= 1'b0;
            zero_reg <= 1'b0;
        end
        else
        begin
            div_go_reg <= 1'b0;
            zero_reg <= rd_zero;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        px_reg <= q_cmd.pixel;
                        if (q_cmd.op == iibb_pkg::OP_LOAD)
                        begin
                            state_reg <= S_LRD;
                        end
                        else
                        begin
                            y1_reg <= (yc >= rad_ext) ? yc - rad_ext : '0;
                            x1_reg <= (xc >= rad_ext) ? xc - rad_ext : '0;
                            y0_reg <= (ty >= rows_eff) ? rows_eff - DW'(1) : ty;
                            x0_reg <= (tx >= cols_eff) ? cols_eff - DW'(1) : tx;
                            state_reg <= S_FSET;
                        end
                    end
                end
                S_LRD: state_reg <= S_LWR;
                S_LWR:
                begin
                    rsum_reg <= rsum_new;
                    lcol_reg <= col_nxt;
                    lrow_reg <= row_nxt;
                    state_reg <= S_IDLE;
                end
                S_FSET:
                begin
                    area_reg <= 18'((y0_reg - y1_reg + DW'(1)) *
                                    (x0_reg - x1_reg + DW'(1)));
                    state_reg <= S_FRD0;
                end
                S_FRD0: state_reg <= S_FRD1;
                S_FRD1:
                begin
                    acc_reg <= rd_val;
                    state_reg <= S_FRD2;
                end
                S_FRD2:
                begin
                    acc_reg <= acc_reg - rd_val;
                    state_reg <= S_FRD3;
                end
                S_FRD3:
                begin
                    acc_reg <= acc_reg - rd_val;
                    state_reg <= S_FSUM;
                end
                S_FSUM:
                begin
                    acc_reg <= acc_reg + rd_val;
                    state_reg <= S_FDIV;
                end
                S_FDIV:
                begin
                    div_go_reg <= 1'b1;
                    state_reg <= S_FWAIT;
                end
                S_FWAIT:
                begin
                    if (div_done)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    iibb_div u_div
    (
        .clk(clk),
        .rst_n(rst_n),
        .go(div_go_reg),
        .dividend(acc_reg),
        .divisor(area_reg),
        .done(div_done),
        .quot_sat(quot)
    );

endmodule
